/* hw/rtl/assert_macros.svh */
// Assertion macros used by quaternion_to_roll_angle.sv, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/qra_pkg.sv */
// Types and constants of the quaternion roll angle pipeline.
`default_nettype none

package qra_pkg;

   localparam int VEC_W    = 36;
   localparam int ACC_W    = 32;
   localparam int ATAN_LEN = 24;

   typedef logic [ACC_W-1:0] angle_type;

   localparam angle_type QUARTER_TURN = 32'h4000_0000;
   localparam angle_type ROUND_HALF   = 32'h0000_8000;

   localparam angle_type ATAN_TAB [ATAN_LEN] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   typedef struct packed {
      logic                    zero;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      angle_type               acc;
   } cordic_vec_type;

endpackage

`default_nettype wire

/* hw/rtl/quaternion_to_roll_angle.sv */
// Top level: roll angle of a Q1.14 quaternion through a pipelined vectoring CORDIC.
//
// The req channel carries one quaternion per item; the rsp channel returns one
// roll angle per item, a signed 16-bit binary angle where 32768 stands for pi.
// Both channels use tvalid/tready; an item moves when both are high.
// From acceptance to rsp_tvalid an item passes one stage of six 16x16 products,
// one of partial sums, one for the quarter-turn pre-rotation, one per
// micro-rotation, and the rounding output register. Throughput is one item per
// cycle while rsp_tready is high, set by the fully pipelined datapath.
// Every stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and the input keeps taking items while
// a finished result waits on rsp. When rsp_tready stays low the pipeline fills
// and req_tready drops; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
`default_nettype none
`include "assert_macros.svh"

module quaternion_to_roll_angle #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata   // roll_angle
);
   import qra_pkg::*;

   localparam int NUM_ST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;

   logic               mul_vld_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, yz_ff, wx_ff;

   logic                    sum_vld_ff;
   logic [32:0]             pos_ff, pos_in;
   logic [32:0]             neg_ff, neg_in;
   logic signed [VEC_W-1:0] vy_ff, vy_in;

   logic                    pre_vld_ff;
   cordic_vec_type          pre_vec_ff, pre_vec_in;
   logic signed [VEC_W-1:0] vx;

   logic           cor_vld [NUM_ST];
   cordic_vec_type cor_vec [NUM_ST];
   logic           cor_rdy [NUM_ST+1];

   logic        rsp_vld_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;
   angle_type   acc_rnd;

   logic out_rdy, pre_rdy, sum_rdy, mul_rdy;

   assign quat_w = req_tdata[15:0];
   assign quat_x = req_tdata[31:16];
   assign quat_y = req_tdata[47:32];
   assign quat_z = req_tdata[63:48];

   assign out_rdy         = !rsp_vld_ff || rsp_tready;
   assign cor_rdy[NUM_ST] = out_rdy;
   assign pre_rdy         = !pre_vld_ff || cor_rdy[0];
   assign sum_rdy         = !sum_vld_ff || pre_rdy;
   assign mul_rdy         = !mul_vld_ff || sum_rdy;
   assign req_tready      = mul_rdy;

   always_ff @(posedge clock) begin
      if (mul_rdy) begin
         ww_ff <= 32'(quat_w) * 32'(quat_w);
         xx_ff <= 32'(quat_x) * 32'(quat_x);
         yy_ff <= 32'(quat_y) * 32'(quat_y);
         zz_ff <= 32'(quat_z) * 32'(quat_z);
         yz_ff <= 32'(quat_y) * 32'(quat_z);
         wx_ff <= 32'(quat_w) * 32'(quat_x);
      end
   end

   always_comb begin
      pos_in = {1'b0, ww_ff} + {1'b0, zz_ff};
      neg_in = {1'b0, xx_ff} + {1'b0, yy_ff};
      vy_in  = (VEC_W'(yz_ff) + VEC_W'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (sum_rdy) begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         vy_ff  <= vy_in;
      end
   end

   always_comb begin
      vx              = $signed(VEC_W'(pos_ff) - VEC_W'(neg_ff));
      pre_vec_in.zero = (vx == '0) && (vy_ff == '0);
      pre_vec_in.x    = vx;
      pre_vec_in.y    = vy_ff;
      pre_vec_in.acc  = '0;
      if (vx < 0) begin
         if (vy_ff >= 0) begin
            pre_vec_in.x   = vy_ff;
            pre_vec_in.y   = -vx;
            pre_vec_in.acc = QUARTER_TURN;
         end else begin
            pre_vec_in.x   = -vy_ff;
            pre_vec_in.y   = vx;
            pre_vec_in.acc = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pre_rdy) begin
         pre_vec_ff <= pre_vec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
         pre_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (mul_rdy) begin
            mul_vld_ff <= req_tvalid;
         end
         if (sum_rdy) begin
            sum_vld_ff <= mul_vld_ff;
         end
         if (pre_rdy) begin
            pre_vld_ff <= sum_vld_ff;
         end
         if (out_rdy) begin
            rsp_vld_ff <= cor_vld[NUM_ST-1];
         end
      end
   end

   for (genvar k = 0; k < NUM_ST; k++) begin : g_cordic
      assign cor_rdy[k] = !cor_vld[k] || cor_rdy[k+1];
      if (k == 0) begin : g_first
         qra_cordic_stage #(
            .STAGE (k)
         ) u_stage (
            .clock   (clock),
            .reset   (reset),
            .load    (cor_rdy[k]),
            .in_vld  (pre_vld_ff),
            .in_vec  (pre_vec_ff),
            .out_vld (cor_vld[k]),
            .out_vec (cor_vec[k])
         );
      end else begin : g_rest
         qra_cordic_stage #(
            .STAGE (k)
         ) u_stage (
            .clock   (clock),
            .reset   (reset),
            .load    (cor_rdy[k]),
            .in_vld  (cor_vld[k-1]),
            .in_vec  (cor_vec[k-1]),
            .out_vld (cor_vld[k]),
            .out_vec (cor_vec[k])
         );
      end
   end

   always_comb begin
      acc_rnd     = cor_vec[NUM_ST-1].acc + ROUND_HALF;
      rsp_data_in = cor_vec[NUM_ST-1].zero ? '0 : acc_rnd[ACC_W-1:ACC_W-16];
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_tvalid && !mul_vld_ff,
                "pipeline not empty after reset")
   `ASSERT_NEXT(a_accept_loads, req_tvalid && req_tready, mul_vld_ff,
                "accepted item not in product stage")
   `ASSERT_IMPL(a_zero_vector, pre_vld_ff && pre_vec_ff.zero,
                pre_vec_ff.x == '0 && pre_vec_ff.y == '0, "zero flag set on a nonzero vector")
   `ASSERT_IMPL(a_right_half, pre_vld_ff, !pre_vec_ff.x[VEC_W-1],
                "pre-rotated vector left of the y axis")

endmodule

`default_nettype wire

/* hw/rtl/qra_cordic_stage.sv */
// One registered vectoring micro-rotation of the CORDIC pipeline.
`default_nettype none

module qra_cordic_stage #(
   parameter int STAGE = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  wire                     in_vld,
   input  qra_pkg::cordic_vec_type in_vec,
   output logic                    out_vld,
   output qra_pkg::cordic_vec_type out_vec
);
   import qra_pkg::*;

   localparam angle_type ANGLE = ATAN_TAB[STAGE];

   logic                    vld_ff;
   cordic_vec_type          vec_ff;
   cordic_vec_type          vec_in;
   logic signed [VEC_W-1:0] x_cur;
   logic signed [VEC_W-1:0] y_cur;
   logic signed [VEC_W-1:0] x_sh;
   logic signed [VEC_W-1:0] y_sh;

   always_comb begin
      x_cur       = in_vec.x;
      y_cur       = in_vec.y;
      x_sh        = x_cur >>> STAGE;
      y_sh        = y_cur >>> STAGE;
      vec_in      = in_vec;
      if (y_cur > 0) begin
         vec_in.x   = x_cur + y_sh;
         vec_in.y   = y_cur - x_sh;
         vec_in.acc = in_vec.acc + ANGLE;
      end else begin
         vec_in.x   = x_cur - y_sh;
         vec_in.y   = y_cur + x_sh;
         vec_in.acc = in_vec.acc - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_vec = vec_ff;

endmodule

`default_nettype wire

/* tb/quaternion_to_roll_angle_tb.sv */
// Self-checking testbench of the quaternion roll angle pipeline.
`timescale 1ns / 1ps

module quaternion_to_roll_angle_tb;

   localparam int STAGES       = 16;
   localparam int LATENCY      = STAGES + 4;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CALM_ITEMS   = 200;
   localparam int TABLE_LEN    = 24;
   localparam int ROW_COUNT    = 24;
   localparam int PRINT_LIMIT  = 40;

   localparam logic signed [15:0] QMAX = 16'sh7FFF;
   localparam logic signed [15:0] QMIN = 16'sh8000;
   localparam logic signed [15:0] ONE  = 16'sd16384;
   localparam logic signed [15:0] DIAG = 16'sd11585;
   localparam logic signed [15:0] NIL  = 16'sd0;

   localparam logic [31:0] QUARTER_BAM = 32'h4000_0000;
   localparam logic [31:0] HALF_LSB    = 32'h0000_8000;

   localparam logic [31:0] ARCTAN_STEP [TABLE_LEN] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   typedef struct packed {
      logic                known;
      logic [15:0]         roll;
      logic signed [15:0]  w;
      logic signed [15:0]  x;
      logic signed [15:0]  y;
      logic signed [15:0]  z;
   } quat_row_type;

   typedef struct {
      logic [15:0] roll;
      logic [63:0] quat;
   } roll_expect_type;

   localparam quat_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{1'b1, 16'h0000, NIL, NIL, NIL, NIL},
      '{1'b1, 16'h0000, QMAX, -QMAX, QMAX, QMAX},
      '{1'b0, 16'h0000, ONE, NIL, NIL, NIL},
      '{1'b0, 16'h0000, NIL, ONE, NIL, NIL},
      '{1'b0, 16'h0000, NIL, -ONE, NIL, NIL},
      '{1'b0, 16'h0000, QMAX, QMAX, QMAX, QMAX},
      '{1'b0, 16'h0000, QMIN, QMIN, QMIN, QMIN},
      '{1'b0, 16'h0000, QMAX, QMIN, QMAX, QMIN},
      '{1'b0, 16'h0000, QMIN, QMAX, QMIN, QMAX},
      '{1'b0, 16'h0000, NIL, NIL, ONE, NIL},
      '{1'b0, 16'h0000, NIL, NIL, NIL, ONE},
      '{1'b0, 16'h0000, DIAG, DIAG, NIL, NIL},
      '{1'b0, 16'h0000, DIAG, -DIAG, NIL, NIL},
      '{1'b0, 16'h0000, 16'sd1000, 16'sd16000, NIL, NIL},
      '{1'b0, 16'h0000, 16'sd1000, -16'sd16000, NIL, NIL},
      '{1'b0, 16'h0000, 16'sd16000, -16'sd1000, NIL, NIL},
      '{1'b0, 16'h0000, NIL, 16'sd1, NIL, NIL},
      '{1'b0, 16'h0000, 16'sd1, NIL, NIL, NIL},
      '{1'b0, 16'h0000, NIL, NIL, 16'sd1, 16'sd1},
      '{1'b0, 16'h0000, QMIN, NIL, NIL, NIL},
      '{1'b0, 16'h0000, NIL, QMIN, NIL, NIL},
      '{1'b0, 16'h0000, NIL, NIL, QMAX, QMIN},
      '{1'b0, 16'h0000, -16'sd1, ONE, NIL, NIL},
      '{1'b0, 16'h0000, 16'sd1, ONE, NIL, NIL}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   roll_expect_type pending_rolls [$];
   roll_expect_type oldest;
   int              mismatches = 0;
   int              idle_pct = 0;
   bit              calm = 1'b0;

   quaternion_to_roll_angle #(
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] predict_roll(input logic signed [15:0] w, x, y, z);
      longint      vy;
      longint      vx;
      longint      t;
      longint      nx;
      longint      ny;
      logic [31:0] angle;
      logic [31:0] rounded;
      vy = 2 * (longint'(y) * longint'(z) + longint'(w) * longint'(x));
      vx = longint'(w) * longint'(w) - longint'(x) * longint'(x)
           - longint'(y) * longint'(y) + longint'(z) * longint'(z);
      angle = '0;
      if (vx == 0 && vy == 0) begin
         return 16'h0000;
      end
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy;
            vy = -t;
            angle = QUARTER_BAM;
         end else begin
            vx = -vy;
            vy = t;
            angle = -QUARTER_BAM;
         end
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            angle = angle + ARCTAN_STEP[i];
         end else begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            angle = angle - ARCTAN_STEP[i];
         end
         vx = nx;
         vy = ny;
      end
      rounded = angle + HALF_LSB;
      return rounded[31:16];
   endfunction

   function automatic logic signed [15:0] random_component();
      logic signed [15:0] v;
      int                 pick;
      v = 16'($urandom);
      pick = $urandom_range(0, 11);
      case (pick)
         0: begin
            v = QMAX;
         end
         1: begin
            v = QMIN;
         end
         2: begin
            v = NIL;
         end
         3: begin
            v = v >>> $urandom_range(8, 15);
         end
         4, 5: begin
            v = v >>> $urandom_range(1, 4);
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] quat,
                                  input logic [15:0] got, input logic [15:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t: %s, quaternion %h, roll %h, expected %h", $time, what, quat, got, want);
      end
      mismatches++;
   endtask

   task automatic send_quat(input logic signed [15:0] w, x, y, z,
                            input logic known, input logic [15:0] roll);
      logic [15:0] want;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tdata  <= {z, y, x, w};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want = known ? roll : predict_roll(w, x, y, z);
      pending_rolls.push_back('{want, {z, y, x, w}});
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rolls.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rolls.size() == 0) begin
            report_mismatch("unexpected item", 64'h0, rsp_tdata, 16'h0000);
         end else begin
            oldest = pending_rolls.pop_front();
            if (rsp_tdata !== oldest.roll) begin
               report_mismatch("roll_angle mismatch", oldest.quat, rsp_tdata, oldest.roll);
            end
         end
      end
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      logic signed [15:0] a;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 10;
      foreach (DIRECTED_ROWS[r]) begin
         send_quat(DIRECTED_ROWS[r].w, DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y,
                   DIRECTED_ROWS[r].z, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].roll);
      end
      drain_pipeline();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 5;
               default: idle_pct = 20;
            endcase
         end
         if (n == RANDOM_ITEMS / 2) begin
            drain_pipeline();
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
         end
         if ($urandom_range(0, 49) == 0) begin
            a = 16'($urandom);
            send_quat(a, -a, a, a, 1'b0, 16'h0000);
         end else begin
            send_quat(random_component(), random_component(), random_component(),
                      random_component(), 1'b0, 16'h0000);
         end
      end
      drain_pipeline();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("quaternion_to_roll_angle_tb passed");
      end else begin
         $display("quaternion_to_roll_angle_tb failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("quaternion_to_roll_angle_tb failed");
      $finish;
   end

endmodule
